FILE: sv/evt3d_pkg.sv
// Shared types and constants for the EVT3 event stream decoder.
// Used by evt3d_decode, evt3d_drain and evt3_event_stream_decoder; no dependencies.
`timescale 1ns / 1ps

package evt3d_pkg;

  // Default width of the internal time base
  localparam int TIME_BITS_DEF = 40;

  // Field widths
  localparam int WORD_W    = 16;
  localparam int COL_W     = 16;
  localparam int ROW_W     = 11;
  localparam int GEOM_W    = 12;
  localparam int WINDOW_W  = 24;
  localparam int COUNT_W   = 24;
  localparam int OTIME_W   = 40;
  localparam int CFG_IDX_W = 2;
  localparam int CFG_DATA_W = 24;
  localparam int VEC_N     = 12;
  localparam int VEC_IDX_W = 4;

  // Register indexes on the configuration port
  localparam logic [CFG_IDX_W-1:0] REG_WIDTH  = 2'd0;
  localparam logic [CFG_IDX_W-1:0] REG_HEIGHT = 2'd1;
  localparam logic [CFG_IDX_W-1:0] REG_WINDOW = 2'd2;

  // Reset values of the configuration registers
  localparam logic [GEOM_W-1:0]   WIDTH_RST  = 12'd1280;
  localparam logic [GEOM_W-1:0]   HEIGHT_RST = 12'd720;
  localparam logic [WINDOW_W-1:0] WINDOW_RST = 24'd33333;

  // A high-time step backward larger than this counts as a rollover
  localparam logic [11:0] REVERSE_GAP = 12'd10;
  localparam logic [COUNT_W-1:0] COUNT_MAX = '1;

  // EVT3 word codes
  localparam logic [3:0] CODE_ROW      = 4'h0;
  localparam logic [3:0] CODE_COL      = 4'h2;
  localparam logic [3:0] CODE_VBASE    = 4'h3;
  localparam logic [3:0] CODE_VEC12    = 4'h4;
  localparam logic [3:0] CODE_VEC8     = 4'h5;
  localparam logic [3:0] CODE_TIME_LOW = 4'h6;
  localparam logic [3:0] CODE_IGN_7    = 4'h7;
  localparam logic [3:0] CODE_TIME_HI  = 4'h8;
  localparam logic [3:0] CODE_IGN_A    = 4'hA;
  localparam logic [3:0] CODE_IGN_E    = 4'hE;
  localparam logic [3:0] CODE_IGN_F    = 4'hF;

  // Result kinds
  typedef enum logic [1:0] {
    KIND_PIXEL = 2'd0,
    KIND_FRAME = 2'd1,
    KIND_ERROR = 2'd2
  } kind_e;

  // One decoded word: a set of results drained one per cycle while ready
  typedef struct packed {
    kind_e                 kind;
    logic [VEC_N-1:0]      mask;     // one bit per result still to send
    logic [COL_W-1:0]      base;     // column of mask bit 0
    logic [ROW_W-1:0]      row;
    logic [COUNT_W-1:0]    events;
    logic [OTIME_W-1:0]    ftime;
  } job_t;

endpackage

FILE: sv/evt3_event_stream_decoder.sv
// EVT3 event stream decoder, top level: decoder plus result register.
// Depends on evt3d_pkg, evt3d_decode and evt3d_drain.
`timescale 1ns / 1ps

// Takes one 16-bit EVT3 word per request on the input channel and gives pixel events,
// frame-end markers and unsupported-code flags on the output channel, one result per
// cycle while out_ready_i is high. Words are dropped until a time-high word is
// followed by a time-low word. A word is decoded in the cycle it is accepted; its
// results sit in a result register, so the next word is taken in the same cycle as
// the final result of the previous one. A vector word yields up to 12 pixel events,
// drained one mask bit per cycle while the receiver is ready. Configuration writes
// (width, height, frame window) take effect at once and should be made while idle.

module evt3_event_stream_decoder import evt3d_pkg::*; #(
  parameter int TIME_BITS = TIME_BITS_DEF
) (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  logic                  cfg_we_i,
  input  logic [CFG_IDX_W-1:0]  cfg_index_i,
  input  logic [CFG_DATA_W-1:0] cfg_data_i,
  input  logic                  in_valid_i,
  output logic                  in_ready_o,
  input  logic [WORD_W-1:0]     word_i,
  output logic                  out_valid_o,
  input  logic                  out_ready_i,
  output logic [1:0]            kind_o,
  output logic [COL_W-1:0]      col_o,
  output logic [ROW_W-1:0]      row_o,
  output logic [COUNT_W-1:0]    frame_events_o,
  output logic [OTIME_W-1:0]    frame_time_o,
  output logic                  last_o
);

  logic accept;
  logic job_valid;
  job_t job;

  assign accept = in_valid_i && in_ready_o;

  evt3d_decode #(
    .TIME_BITS (TIME_BITS)
  ) u_decode (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_we_i    (cfg_we_i),
    .cfg_index_i (cfg_index_i),
    .cfg_data_i  (cfg_data_i),
    .word_i      (word_i),
    .accept_i    (accept),
    .job_o       (job),
    .job_valid_o (job_valid)
  );

  evt3d_drain u_drain (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .load_i         (accept && job_valid),
    .job_i          (job),
    .can_take_o     (in_ready_o),
    .out_valid_o    (out_valid_o),
    .out_ready_i    (out_ready_i),
    .kind_o         (kind_o),
    .col_o          (col_o),
    .row_o          (row_o),
    .frame_events_o (frame_events_o),
    .frame_time_o   (frame_time_o),
    .last_o         (last_o)
  );

endmodule

FILE: sv/evt3d_decode.sv
// Word decoder: configuration registers, time base, row/column state and event count.
// Depends on evt3d_pkg; produces one job_t per word that yields results.
`timescale 1ns / 1ps

module evt3d_decode import evt3d_pkg::*; #(
  parameter int TIME_BITS = TIME_BITS_DEF
) (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  logic                  cfg_we_i,
  input  logic [CFG_IDX_W-1:0]  cfg_index_i,
  input  logic [CFG_DATA_W-1:0] cfg_data_i,
  input  logic [WORD_W-1:0]     word_i,
  input  logic                  accept_i,
  output job_t                  job_o,
  output logic                  job_valid_o
);

  logic [GEOM_W-1:0]    width_q, height_q;
  logic [WINDOW_W-1:0]  window_q;

  logic                 time_valid_q, high_seen_q;
  logic [TIME_BITS-1:0] high_q, high_d;
  logic [ROW_W-1:0]     row_q;
  logic [COL_W-1:0]     base_q, base_d;
  logic [TIME_BITS-1:0] limit_q, limit_d;
  logic [COUNT_W-1:0]   count_q, count_d;

  logic [3:0]           code;
  logic [11:0]          pay;
  logic                 row_ok;
  logic [COL_W-1:0]     pix_base;
  logic [VEC_N-1:0]     raw_mask, ev_mask;
  logic [VEC_IDX_W:0]   ev_cnt;
  logic [COUNT_W:0]     cnt_sum;
  logic [TIME_BITS-1:0] now, lim_next, high_inc;
  logic [63:0]          now_w;
  logic [11:0]          prev_hi;
  logic                 rollover;

  assign code = word_i[15:12];
  assign pay  = word_i[11:0];

  // Pixel candidates: a single column word or a vector mask
  assign row_ok = {1'b0, row_q} < height_q;

  always_comb begin
    pix_base = base_q;
    raw_mask = '0;
    if (code == CODE_COL) begin
      pix_base    = COL_W'(pay[10:0]);
      raw_mask[0] = 1'b1;
    end else if (code == CODE_VEC12) begin
      raw_mask = pay;
    end else if (code == CODE_VEC8) begin
      raw_mask = {4'b0, pay[7:0]};
    end
  end

  always_comb begin
    ev_cnt = '0;
    for (int i = 0; i < VEC_N; i++) begin
      ev_mask[i] = raw_mask[i] && row_ok &&
                   ((pix_base + COL_W'(i)) < COL_W'(width_q));
      ev_cnt     = ev_cnt + (VEC_IDX_W+1)'(ev_mask[i]);
    end
  end

  // Saturating add of the new pixel events
  assign cnt_sum = {1'b0, count_q} + (COUNT_W+1)'(ev_cnt);

  // Time base arithmetic
  assign now      = {high_q[TIME_BITS-1:12], pay};
  assign now_w    = 64'(now);
  assign lim_next = now + TIME_BITS'(window_q);
  assign prev_hi  = high_q[23:12];
  assign rollover = (pay < prev_hi) && ((prev_hi - pay) > REVERSE_GAP);
  assign high_inc = {high_q[TIME_BITS-1:24] + (TIME_BITS-24)'(1), high_q[23:0]};

  // Per-word decode: next state and the job to hand on
  always_comb begin
    high_d      = high_q;
    base_d      = base_q;
    limit_d     = limit_q;
    count_d     = count_q;
    job_valid_o = 1'b0;
    job_o.kind   = KIND_PIXEL;
    job_o.mask   = ev_mask;
    job_o.base   = pix_base;
    job_o.row    = row_q;
    job_o.events = '0;
    job_o.ftime  = '0;

    if (time_valid_q) begin
      unique case (code)
        CODE_ROW, CODE_VBASE, CODE_IGN_7, CODE_IGN_A, CODE_IGN_E, CODE_IGN_F: begin
        end
        CODE_COL, CODE_VEC12, CODE_VEC8: begin
          job_valid_o = |ev_mask;
          count_d = cnt_sum[COUNT_W] ? COUNT_MAX : cnt_sum[COUNT_W-1:0];
          if (code == CODE_VEC12) begin
            base_d = base_q + COL_W'(12);
          end else if (code == CODE_VEC8) begin
            base_d = base_q + COL_W'(8);
          end
        end
        CODE_TIME_HI: begin
          high_d = {(rollover ? high_inc[TIME_BITS-1:24] : high_q[TIME_BITS-1:24]),
                    pay, 12'b0};
        end
        CODE_TIME_LOW: begin
          if (limit_q == '0) begin
            limit_d = lim_next;
          end else if (now > limit_q) begin
            limit_d = lim_next;
            if (count_q != '0) begin
              job_valid_o  = 1'b1;
              job_o.kind   = KIND_FRAME;
              job_o.mask   = VEC_N'(1);
              job_o.base   = '0;
              job_o.row    = '0;
              job_o.events = count_q;
              job_o.ftime  = now_w[OTIME_W-1:0];
              count_d      = '0;
            end
          end
        end
        default: begin
          job_valid_o = 1'b1;
          job_o.kind  = KIND_ERROR;
          job_o.mask  = VEC_N'(1);
          job_o.base  = '0;
          job_o.row   = '0;
        end
      endcase
    end
  end

  // Configuration and decoder state
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      width_q      <= WIDTH_RST;
      height_q     <= HEIGHT_RST;
      window_q     <= WINDOW_RST;
      time_valid_q <= 1'b0;
      high_seen_q  <= 1'b0;
      high_q       <= '0;
      row_q        <= '0;
      base_q       <= '0;
      limit_q      <= '0;
      count_q      <= '0;
    end else begin
      if (cfg_we_i) begin
        if (cfg_index_i == REG_WIDTH) begin
          width_q <= cfg_data_i[GEOM_W-1:0];
        end else if (cfg_index_i == REG_HEIGHT) begin
          height_q <= cfg_data_i[GEOM_W-1:0];
        end else if (cfg_index_i == REG_WINDOW) begin
          window_q <= cfg_data_i[WINDOW_W-1:0];
        end
      end
      if (accept_i) begin
        if (!time_valid_q) begin
          // waiting for a time-high then time-low pair
          if (code == CODE_TIME_HI) begin
            high_seen_q <= 1'b1;
          end else if (code == CODE_TIME_LOW && high_seen_q) begin
            time_valid_q <= 1'b1;
          end
        end else begin
          if (code == CODE_ROW) begin
            row_q <= pay[10:0];
          end
          if (code == CODE_VBASE) begin
            base_q <= COL_W'(pay[10:0]);
          end else begin
            base_q <= base_d;
          end
          high_q  <= high_d;
          limit_q <= limit_d;
          count_q <= count_d;
        end
      end
    end
  end

endmodule

FILE: sv/evt3d_drain.sv
// Result register: holds a decoded job; sends a result per cycle when ready.
// Depends on evt3d_pkg (job_t, kind_e).
`timescale 1ns / 1ps

module evt3d_drain import evt3d_pkg::*; (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               load_i,
  input  job_t               job_i,
  output logic               can_take_o,
  output logic               out_valid_o,
  input  logic               out_ready_i,
  output logic [1:0]         kind_o,
  output logic [COL_W-1:0]   col_o,
  output logic [ROW_W-1:0]   row_o,
  output logic [COUNT_W-1:0] frame_events_o,
  output logic [OTIME_W-1:0] frame_time_o,
  output logic               last_o
);

  logic [VEC_N-1:0]     mask_q, rest;
  kind_e                kind_q;
  logic [COL_W-1:0]     base_q;
  logic [ROW_W-1:0]     row_q;
  logic [COUNT_W-1:0]   events_q;
  logic [OTIME_W-1:0]   ftime_q;
  logic [VEC_IDX_W-1:0] idx;

  // Lowest pending mask bit is the result on the port
  always_comb begin
    idx = '0;
    for (int i = VEC_N - 1; i >= 0; i--) begin
      if (mask_q[i]) begin
        idx = VEC_IDX_W'(i);
      end
    end
  end

  assign rest        = mask_q & (mask_q - VEC_N'(1));
  assign out_valid_o = |mask_q;
  assign last_o      = (rest == '0);
  assign can_take_o  = !out_valid_o || (out_ready_i && last_o);

  assign kind_o         = kind_q;
  assign col_o          = (kind_q == KIND_PIXEL) ? base_q + COL_W'(idx) : '0;
  assign row_o          = (kind_q == KIND_PIXEL) ? row_q : '0;
  assign frame_events_o = events_q;
  assign frame_time_o   = ftime_q;

  // Pending mask has reset; payload does not
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      mask_q <= '0;
    end else if (load_i) begin
      mask_q <= job_i.mask;
    end else if (out_valid_o && out_ready_i) begin
      mask_q <= rest;
    end
  end

  always_ff @(posedge clk_i) begin
    if (load_i) begin
      kind_q   <= job_i.kind;
      base_q   <= job_i.base;
      row_q    <= job_i.row;
      events_q <= job_i.events;
      ftime_q  <= job_i.ftime;
    end
  end

endmodule

FILE: tb/sv/evt3_tb_pkg.sv
// Testbench support for the EVT3 event stream decoder: result type and scoreboard.
// Depends on evt3d_pkg for widths, codes, register indexes and reset values.
`timescale 1ns / 1ps

package evt3_tb_pkg;

  import evt3d_pkg::*;

  // Codes the decoder flags as unsupported
  localparam logic [3:0] CODE_ERR_1 = 4'h1;
  localparam logic [3:0] CODE_ERR_9 = 4'h9;
  localparam logic [3:0] CODE_ERR_B = 4'hB;
  localparam logic [3:0] CODE_ERR_C = 4'hC;
  localparam logic [3:0] CODE_ERR_D = 4'hD;

  // One result as seen on the output channel
  typedef struct packed {
    kind_e                 kind;
    logic [COL_W-1:0]      col;
    logic [ROW_W-1:0]      row;
    logic [COUNT_W-1:0]    events;
    logic [OTIME_W-1:0]    ftime;
    logic                  last;
  } result_t;

  // Tracks decoder state, predicts the results of each request and checks them
  class evt3_scoreboard;

    logic [GEOM_W-1:0]        width_cfg;
    logic [GEOM_W-1:0]        height_cfg;
    logic [WINDOW_W-1:0]      window_cfg;

    bit                       synced;
    bit                       high_seen;
    logic [TIME_BITS_DEF-1:0] high_time;
    logic [11:0]              low_time;
    logic [ROW_W-1:0]         cur_row;
    logic [COL_W-1:0]         base_col;
    logic [TIME_BITS_DEF-1:0] frame_limit;
    logic [COUNT_W-1:0]       event_count;

    result_t                  pending_results[$];
    int unsigned              errors;

    function new();
      width_cfg   = WIDTH_RST;
      height_cfg  = HEIGHT_RST;
      window_cfg  = WINDOW_RST;
      synced      = 1'b0;
      high_seen   = 1'b0;
      high_time   = '0;
      low_time    = '0;
      cur_row     = '0;
      base_col    = '0;
      frame_limit = '0;
      event_count = '0;
      errors      = 0;
    endfunction

    function void set_reg(input logic [CFG_IDX_W-1:0] idx, input logic [CFG_DATA_W-1:0] data);
      case (idx)
        REG_WIDTH:  width_cfg = data[GEOM_W-1:0];
        REG_HEIGHT: height_cfg = data[GEOM_W-1:0];
        REG_WINDOW: window_cfg = data[WINDOW_W-1:0];
        default: ;
      endcase
    endfunction

    function void push_result(input kind_e kind, input logic [COL_W-1:0] col,
                              input logic [ROW_W-1:0] row, input logic [COUNT_W-1:0] events,
                              input logic [OTIME_W-1:0] ftime);
      result_t r;
      r.kind   = kind;
      r.col    = col;
      r.row    = row;
      r.events = events;
      r.ftime  = ftime;
      r.last   = 1'b0;
      pending_results.insert(pending_results.size(), r);
    endfunction

    // Pixel survives only inside the configured geometry; the counter saturates
    function void add_pixel(input logic [COL_W-1:0] col);
      if (col < width_cfg && cur_row < height_cfg) begin
        push_result(KIND_PIXEL, col, cur_row, '0, '0);
        if (event_count != COUNT_MAX)
          event_count = event_count + 1'b1;
      end
    endfunction

    function void add_vector(input logic [VEC_N-1:0] mask, input int unsigned n);
      for (int unsigned i = 0; i < n; i++)
        if (mask[i])
          add_pixel(base_col + COL_W'(i));
      base_col = base_col + COL_W'(n);
    endfunction

    // Decode one accepted request into its expected results
    function void note_word(input logic [WORD_W-1:0] w);
      logic [3:0]               code;
      logic [11:0]              pay;
      logic [11:0]              prev;
      logic [TIME_BITS_DEF-1:0] now;
      int unsigned              before_n;
      result_t                  tail;
      code     = w[15:12];
      pay      = w[11:0];
      before_n = pending_results.size();

      // Until a time-high then time-low pair, everything is dropped
      if (!synced) begin
        if (code == CODE_TIME_HI)
          high_seen = 1'b1;
        else if (code == CODE_TIME_LOW && high_seen)
          synced = 1'b1;
        return;
      end

      case (code)
        CODE_ROW:   cur_row = pay[ROW_W-1:0];
        CODE_COL:   add_pixel(COL_W'(pay[ROW_W-1:0]));
        CODE_VBASE: base_col = COL_W'(pay[ROW_W-1:0]);
        CODE_VEC12: add_vector(pay, VEC_N);
        CODE_VEC8:  add_vector({4'b0000, pay[7:0]}, 8);
        CODE_TIME_LOW: begin
          low_time = pay;
          now = high_time | TIME_BITS_DEF'(low_time);
          if (frame_limit == '0) begin
            frame_limit = now + TIME_BITS_DEF'(window_cfg);
          end else if (now > frame_limit) begin
            if (event_count != '0) begin
              push_result(KIND_FRAME, '0, '0, event_count, OTIME_W'(now));
              event_count = '0;
            end
            frame_limit = now + TIME_BITS_DEF'(window_cfg);
          end
        end
        CODE_TIME_HI: begin
          // rollover only on a real step backward, not on jitter
          prev = high_time[23:12];
          if (pay < prev && prev - pay > REVERSE_GAP)
            high_time = high_time + (TIME_BITS_DEF'(1) << 24);
          high_time = {high_time[TIME_BITS_DEF-1:24], pay, 12'h000};
        end
        CODE_IGN_7, CODE_IGN_A, CODE_IGN_E, CODE_IGN_F: ;
        default: push_result(KIND_ERROR, '0, '0, '0, '0);
      endcase

      if (pending_results.size() > before_n) begin
        tail = pending_results[pending_results.size() - 1];
        tail.last = 1'b1;
        pending_results[pending_results.size() - 1] = tail;
      end
    endfunction

    task report(input string msg);
      $display("[%0t] mismatch: %s", $time, msg);
      errors++;
    endtask

    task check_result(input logic [1:0] kind, input logic [COL_W-1:0] col,
                      input logic [ROW_W-1:0] row, input logic [COUNT_W-1:0] events,
                      input logic [OTIME_W-1:0] ftime, input logic last);
      result_t want;
      if (pending_results.size() == 0) begin
        report($sformatf("result kind %0d col %0d row %0d with nothing pending",
                         kind, col, row));
        return;
      end
      want = pending_results.pop_front();
      if (kind !== want.kind)
        report($sformatf("kind got %0d want %0d", kind, want.kind));
      if (col !== want.col)
        report($sformatf("col got %0d want %0d", col, want.col));
      if (row !== want.row)
        report($sformatf("row got %0d want %0d", row, want.row));
      if (events !== want.events)
        report($sformatf("frame_events got %0d want %0d", events, want.events));
      if (ftime !== want.ftime)
        report($sformatf("frame_time got %0h want %0h", ftime, want.ftime));
      if (last !== want.last)
        report($sformatf("last got %0b want %0b", last, want.last));
    endtask

  endclass

endpackage

FILE: tb/sv/tb_evt3_event_stream_decoder.sv
// Testbench top for evt3_event_stream_decoder: drives EVT3 words and checks results.
// Depends on evt3d_pkg, evt3_tb_pkg and the decoder RTL.
`timescale 1ns / 1ps

module tb_evt3_event_stream_decoder;

  import evt3d_pkg::*;
  import evt3_tb_pkg::*;

  localparam int unsigned IDLE_PCT     = 23;
  localparam int unsigned DRAIN_CYCLES = 4;
  localparam int unsigned END_SPIN     = 2000;
  localparam longint      TIMEOUT_NS   = 30_000_000;

  logic                  clk_i       = 1'b0;
  logic                  rst_ni      = 1'b0;
  logic                  cfg_we_i    = 1'b0;
  logic [CFG_IDX_W-1:0]  cfg_index_i = '0;
  logic [CFG_DATA_W-1:0] cfg_data_i  = '0;
  logic                  in_valid_i  = 1'b0;
  logic                  in_ready_o;
  logic [WORD_W-1:0]     word_i      = '0;
  logic                  out_valid_o;
  logic                  out_ready_i = 1'b0;
  logic [1:0]            kind_o;
  logic [COL_W-1:0]      col_o;
  logic [ROW_W-1:0]      row_o;
  logic [COUNT_W-1:0]    frame_events_o;
  logic [OTIME_W-1:0]    frame_time_o;
  logic                  last_o;

  evt3_scoreboard        book;
  bit                    calm = 1'b0;     // no idling on either side while set
  logic [11:0]           hi_pay = 12'h020;
  logic [WORD_W-1:0]     opening [$];

  evt3_event_stream_decoder uut (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .cfg_we_i       (cfg_we_i),
    .cfg_index_i    (cfg_index_i),
    .cfg_data_i     (cfg_data_i),
    .in_valid_i     (in_valid_i),
    .in_ready_o     (in_ready_o),
    .word_i         (word_i),
    .out_valid_o    (out_valid_o),
    .out_ready_i    (out_ready_i),
    .kind_o         (kind_o),
    .col_o          (col_o),
    .row_o          (row_o),
    .frame_events_o (frame_events_o),
    .frame_time_o   (frame_time_o),
    .last_o         (last_o)
  );

  // 10 ns clock
  always begin
    #5 clk_i = 1'b1;
    #5 clk_i = 1'b0;
  end

  // Receiver stalls at random unless in a calm stretch
  always @(posedge clk_i) begin
    out_ready_i <= calm || ($urandom_range(0, 99) >= IDLE_PCT);
  end

  // Both channels sampled at the edge: predict on each request, then check results
  always @(posedge clk_i) begin
    if (rst_ni) begin
      if (in_valid_i && in_ready_o)
        book.note_word(word_i);
      if (out_valid_o && out_ready_i)
        book.check_result(kind_o, col_o, row_o, frame_events_o, frame_time_o, last_o);
    end
  end

  task automatic send_word(input logic [WORD_W-1:0] w);
    while (!calm && $urandom_range(0, 99) < IDLE_PCT) begin
      in_valid_i <= 1'b0;
      @(posedge clk_i);
    end
    in_valid_i <= 1'b1;
    word_i     <= w;
    do @(posedge clk_i); while (!in_ready_o);
  endtask

  task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [CFG_DATA_W-1:0] data);
    cfg_we_i    <= 1'b1;
    cfg_index_i <= idx;
    cfg_data_i  <= data;
    @(posedge clk_i);
    book.set_reg(idx, data);
  endtask

  task automatic set_config(input int unsigned w, input int unsigned h, input int unsigned win);
    write_reg(REG_WIDTH, CFG_DATA_W'(w));
    write_reg(REG_HEIGHT, CFG_DATA_W'(h));
    write_reg(REG_WINDOW, CFG_DATA_W'(win));
    cfg_we_i <= 1'b0;
  endtask

  // Hold the sender until every predicted result is out, then let the block settle
  task automatic wait_idle();
    in_valid_i <= 1'b0;
    @(posedge clk_i);
    while (book.pending_results.size() != 0)
      @(posedge clk_i);
    repeat (DRAIN_CYCLES) @(posedge clk_i);
  endtask

  // Half the time keep the address inside the configured bound so events pass
  function automatic logic [11:0] near_limit(input logic [GEOM_W-1:0] lim);
    logic [11:0] pay;
    pay = 12'($urandom);
    if (lim != 0 && $urandom_range(0, 1) == 0)
      pay[10:0] = 11'($urandom_range(0, lim - 1));
    return pay;
  endfunction

  // Mostly well-formed traffic with a drifting time base, some noise
  function automatic logic [WORD_W-1:0] pick_word();
    int unsigned r;
    logic [3:0]  code;
    logic [11:0] pay;
    r   = $urandom_range(0, 99);
    pay = 12'($urandom);
    if (r < 14) begin
      code = CODE_ROW;
      pay  = near_limit(book.height_cfg);
    end else if (r < 34) begin
      code = CODE_COL;
      pay  = near_limit(book.width_cfg);
    end else if (r < 42) begin
      code = CODE_VBASE;
      pay  = near_limit(book.width_cfg);
    end else if (r < 52) begin
      code = CODE_VEC12;
    end else if (r < 60) begin
      code = CODE_VEC8;
    end else if (r < 74) begin
      code = CODE_TIME_LOW;
    end else if (r < 84) begin
      code = CODE_TIME_HI;
      // mostly forward, sometimes a jump, sometimes a step back near the rollover gap
      case ($urandom_range(0, 9))
        0:       hi_pay = 12'($urandom);
        1:       hi_pay = hi_pay - 12'($urandom_range(9, 12));
        default: hi_pay = hi_pay + 12'($urandom_range(0, 3));
      endcase
      pay = hi_pay;
    end else if (r < 90) begin
      case ($urandom_range(0, 3))
        0:       code = CODE_IGN_7;
        1:       code = CODE_IGN_A;
        2:       code = CODE_IGN_E;
        default: code = CODE_IGN_F;
      endcase
    end else if (r < 95) begin
      case ($urandom_range(0, 4))
        0:       code = CODE_ERR_1;
        1:       code = CODE_ERR_9;
        2:       code = CODE_ERR_B;
        3:       code = CODE_ERR_C;
        default: code = CODE_ERR_D;
      endcase
    end else begin
      code = 4'($urandom);
    end
    return {code, pay};
  endfunction

  task automatic run_random(input int unsigned n);
    repeat (n) send_word(pick_word());
  endtask

  initial begin
    int unsigned spin;
    book = new();
    repeat (5) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // Directed: drop before sync, bounds at default geometry, vectors, all kinds
    // of code, rollover threshold on both sides, then a frame end
    opening = '{
      {CODE_COL,      12'h005},   // no sync yet
      {CODE_TIME_LOW, 12'h123},   // low with no high seen
      {CODE_ERR_1,    12'hFFF},   // unsupported before sync is still silent
      {CODE_TIME_HI,  12'h005},
      {CODE_TIME_LOW, 12'h010},   // sync, itself dropped
      {CODE_ROW,      12'h000},
      {CODE_COL,      12'h000},
      {CODE_COL,      12'h7FF},
      {CODE_ROW,      12'hFFF},
      {CODE_COL,      12'h4FF},
      {CODE_ROW,      12'h2CF},
      {CODE_COL,      12'hCFF},   // last column in bounds, bit 11 ignored
      {CODE_COL,      12'h500},
      {CODE_VBASE,    12'hCFA},
      {CODE_VEC12,    12'hFFF},   // straddles the width limit
      {CODE_VBASE,    12'h000},
      {CODE_VEC8,     12'hA5A},
      {CODE_IGN_7,    12'hABC},
      {CODE_IGN_F,    12'h123},
      {CODE_ERR_9,    12'h000},
      {CODE_ERR_D,    12'h555},
      {CODE_TIME_HI,  12'h010},
      {CODE_TIME_HI,  12'h006},   // back by exactly the gap: no rollover
      {CODE_TIME_HI,  12'h010},
      {CODE_TIME_HI,  12'h005},   // back by one more: rollover
      {CODE_TIME_LOW, 12'hFFF},   // first limit
      {CODE_TIME_HI,  12'h020},
      {CODE_TIME_LOW, 12'h000}    // past the limit with events pending
    };
    foreach (opening[i]) send_word(opening[i]);
    wait_idle();

    // Widest geometry, shortest window, no idling anywhere
    calm <= 1'b1;
    set_config(2048, 2048, 1);
    run_random(120);
    wait_idle();
    calm <= 1'b0;

    // Smallest geometry, longest window
    set_config(1, 1, 24'hFFFFFF);
    run_random(60);
    wait_idle();

    // Mid geometry; the sender holds halfway until all results are out
    set_config(640, 480, 5000);
    run_random(80);
    wait_idle();
    run_random(80);
    wait_idle();

    // Zero geometry drops every event
    set_config(0, 2048, 33333);
    run_random(12);
    wait_idle();
    set_config(2048, 0, 33333);
    run_random(12);
    wait_idle();

    // Vectors from the top of the base range, past the widest geometry
    set_config(2048, 2048, 33333);
    send_word({CODE_VBASE, 12'h7FF});
    send_word({CODE_VEC12, 12'hFFF});
    send_word({CODE_VEC8, 12'h0FF});
    run_random(65);

    // Drain with a bound so leftovers are reported rather than hung on
    in_valid_i <= 1'b0;
    @(posedge clk_i);
    spin = 0;
    while (book.pending_results.size() != 0 && spin < END_SPIN) begin
      @(posedge clk_i);
      spin++;
    end
    repeat (DRAIN_CYCLES) @(posedge clk_i);
    if (book.pending_results.size() != 0)
      book.report($sformatf("%0d expected results never arrived",
                            book.pending_results.size()));

    if (book.errors == 0)
      $display("evt3_event_stream_decoder test passed");
    else
      $display("evt3_event_stream_decoder test failed");
    $finish;
  end

  // Watchdog
  initial begin
    #(TIMEOUT_NS);
    $display("evt3_event_stream_decoder test failed");
    $finish;
  end

endmodule

FILE: evt3_event_stream_decoder.f
sv/evt3d_pkg.sv
sv/evt3d_decode.sv
sv/evt3d_drain.sv
sv/evt3_event_stream_decoder.sv
tb/sv/evt3_tb_pkg.sv
tb/sv/tb_evt3_event_stream_decoder.sv
